// ===== rtl/fixed_point_mul_div_unit_core_assert.svh =====
// ----------------------------------------------------------------------------
// Fixed-point multiply/divide unit - assertion macros
// Concurrent assertion forms for the core RTL file.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_MUL_DIV_UNIT_CORE_ASSERT_SVH
`define FIXED_POINT_MUL_DIV_UNIT_CORE_ASSERT_SVH

// check outside reset
`define FPMD_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define FPMD_CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpmd_pkg
// Widths, operation codes and the divider stage record of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpmd_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int DATA_W          = 32;
	localparam int QUO_W           = DATA_W + FRAC_BITS;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int PAD_W           = DIV_STAGES * STEPS_PER_STAGE;
	localparam int REM_W           = DATA_W + 1;
	localparam int PROD_W          = 2 * DATA_W;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic [PAD_W-1:0] nq;
		logic [REM_W-1:0] rem;
		logic [DATA_W-1:0] den;
		logic              neg;
		logic              dz;
		logic              is_div;
	} div_t;

endpackage

`default_nettype wire

// ===== rtl/fpmd_mul.sv =====
// ----------------------------------------------------------------------------
// fpmd_mul
// Two-stage signed multiply with arithmetic right shift and range check.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmd_mul
	import fpmd_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [DATA_W-1:0] a,
	input  wire logic signed [DATA_W-1:0] b,
	output logic             [DATA_W-1:0] res,
	output logic                          ovf
);

	logic signed [PROD_W-1:0] prod_s1;
	logic        [DATA_W-1:0] res_s2;
	logic                     ovf_s2;
	logic signed [PROD_W-1:0] shifted;

	assign shifted = prod_s1 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a * b;
			res_s2  <= shifted[DATA_W-1:0];
			ovf_s2  <= !((&shifted[PROD_W-1:DATA_W-1]) || !(|shifted[PROD_W-1:DATA_W-1]));
		end
	end

	assign res = res_s2;
	assign ovf = ovf_s2;

endmodule

`default_nettype wire

// ===== rtl/fpmd_div_stage.sv =====
// ----------------------------------------------------------------------------
// fpmd_div_stage
// One registered stage of the restoring divider, several quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmd_div_stage
	import fpmd_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire div_t din,
	output div_t      dout
);

	div_t             nxt;
	logic [REM_W-1:0] trial;
	div_t             dout_s1;

	always_comb begin
		nxt   = din;
		trial = '0;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			trial  = {nxt.rem[REM_W-2:0], nxt.nq[PAD_W-1]};
			nxt.nq = {nxt.nq[PAD_W-2:0], 1'b0};
			if (trial >= REM_W'(nxt.den)) begin
				nxt.rem   = trial - REM_W'(nxt.den);
				nxt.nq[0] = 1'b1;
			end else begin
				nxt.rem = trial;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_s1 <= nxt;
		end
	end

	assign dout = dout_s1;

endmodule

`default_nettype wire

// ===== rtl/fixed_point_mul_div_unit_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_mul_div_unit_core
// Pipelined signed Q16.16 multiply and divide with overflow and zero flags.
// ----------------------------------------------------------------------------
// One item enters per clock cycle unless the output stalls; its result passes
// through an input register, a restoring divider cut into DIV_STAGES stages
// of four quotient bits each, and an output register. The divider sets the
// depth; multiplies ride along in a matched delay line so results leave in
// order. A stall on the output holds the whole pipeline in place.
`default_nettype none

`include "fixed_point_mul_div_unit_core_assert.svh"

module fixed_point_mul_div_unit_core
	import fpmd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [2*DATA_W-1:0] s_tdata,  // operand_a, operand_b
	input  wire logic                s_tuser,  // operation
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [DATA_W-1:0]        m_tdata,  // result
	output logic [1:0]               m_tuser   // overflow, divide_by_zero
);

	logic                     adv;
	logic [DIV_STAGES:0]      vld_s;
	logic signed [DATA_W-1:0] in_a;
	logic signed [DATA_W-1:0] in_b;
	logic [DATA_W-1:0]        mag_a;
	logic [DATA_W-1:0]        mag_b;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;
	div_t                     div_in;
	div_t                     div_s [0:DIV_STAGES];
	logic [DATA_W-1:0]        mul_res;
	logic                     mul_ovf;
	logic [DATA_W-1:0]        mres_s [3:DIV_STAGES];
	logic                     movf_s [3:DIV_STAGES];
	logic [PAD_W-1:0]         mq;
	logic                     hi_nz;
	logic                     is_min;
	logic [DATA_W-1:0]        fin_res;
	logic                     fin_ovf;
	logic                     fin_dz;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_res_q;
	logic                     out_ovf_q;
	logic                     out_dz_q;
	logic                     out_div_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	assign in_a  = signed'(s_tdata[DATA_W-1:0]);
	assign in_b  = signed'(s_tdata[2*DATA_W-1:DATA_W]);
	assign mag_a = in_a[DATA_W-1] ? (~in_a) + DATA_W'(1) : in_a;
	assign mag_b = in_b[DATA_W-1] ? (~in_b) + DATA_W'(1) : in_b;

	always_comb begin
		div_in        = '0;
		div_in.nq     = PAD_W'(mag_a) << FRAC_BITS;
		div_in.rem    = '0;
		div_in.den    = mag_b;
		div_in.neg    = in_a[DATA_W-1] ^ in_b[DATA_W-1];
		div_in.dz     = (in_b == '0);
		div_in.is_div = (op_t'(s_tuser) == OP_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[DIV_STAGES-1:0], s_tvalid};
			out_valid_q <= vld_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1     <= in_a;
			b_s1     <= in_b;
			div_s[0] <= div_in;
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		fpmd_div_stage u_stage (
			.clk  (clk),
			.en   (adv),
			.din  (div_s[k-1]),
			.dout (div_s[k])
		);
	end

	fpmd_mul u_mul (
		.clk (clk),
		.en  (adv),
		.a   (a_s1),
		.b   (b_s1),
		.res (mul_res),
		.ovf (mul_ovf)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			mres_s[3] <= mul_res;
			movf_s[3] <= mul_ovf;
			for (int k = 4; k <= DIV_STAGES; k++) begin
				mres_s[k] <= mres_s[k-1];
				movf_s[k] <= movf_s[k-1];
			end
		end
	end

	assign mq     = div_s[DIV_STAGES].nq;
	assign hi_nz  = |mq[PAD_W-1:DATA_W-1];
	assign is_min = (mq == (PAD_W'(1) << (DATA_W - 1)));

	always_comb begin
		fin_res = mres_s[DIV_STAGES];
		fin_ovf = movf_s[DIV_STAGES];
		fin_dz  = 1'b0;
		if (div_s[DIV_STAGES].is_div) begin
			if (div_s[DIV_STAGES].dz) begin
				fin_res = '0;
				fin_ovf = 1'b0;
				fin_dz  = 1'b1;
			end else if (div_s[DIV_STAGES].neg) begin
				fin_res = (~mq[DATA_W-1:0]) + DATA_W'(1);
				fin_ovf = hi_nz && !is_min;
			end else begin
				fin_res = mq[DATA_W-1:0];
				fin_ovf = hi_nz;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q <= fin_res;
			out_ovf_q <= fin_ovf;
			out_dz_q  <= fin_dz;
			out_div_q <= div_s[DIV_STAGES].is_div;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_res_q;
	assign m_tuser  = {out_dz_q, out_ovf_q};

	`FPMD_CHECK(a_dz_clean, m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0], "dz result not zero")
	`FPMD_CHECK(a_dz_div_only, m_tvalid && m_tuser[1] |-> out_div_q, "dz flag on multiply item")
	`FPMD_CHECK(a_stall_holds, m_tvalid && !m_tready |=> $stable(div_s[DIV_STAGES]) && $stable(vld_s), "pipeline moved during stall")
	`FPMD_CHECK_ALWAYS(a_reset_idle, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule

`default_nettype wire

// ===== bench/tb_fixed_point_mul_div_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_mul_div_unit_core
// Self-checking bench for the pipelined Q16.16 multiply/divide unit: directed
// corner items for both operations and the zero divisor, then random mixes
// under three idling profiles; every result is checked in order against a
// Q16.16 arithmetic predictor.
// ----------------------------------------------------------------------------
module tb_fixed_point_mul_div_unit_core;
	import fpmd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = DIV_STAGES + 8;
	localparam int MAX_PRINTS     = 40;
	localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              overflow;
		logic              divide_by_zero;
	} q16_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [2*DATA_W-1:0] s_tdata = '0;  // operand_a, operand_b
	logic                s_tuser = 1'b0;  // operation
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;  // result
	logic [1:0]          m_tuser;  // overflow, divide_by_zero

	q16_result_t q16_results_due[$];
	q16_result_t due_item;
	int          error_count = 0;
	int          stall_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	fixed_point_mul_div_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic q16_result_t q16_compute(op_t op, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic signed [63:0] sa;
		logic signed [63:0] sb;
		logic signed [63:0] q;
		logic [63:0]        num;
		logic [63:0]        den;
		logic [63:0]        mq;
		q16_result_t        r;
		sa = {{32{a[DATA_W-1]}}, a};
		sb = {{32{b[DATA_W-1]}}, b};
		r = '0;
		if (op == OP_MUL) begin
			q = (sa * sb) >>> FRAC_BITS;
		end else if (b == '0) begin
			r.divide_by_zero = 1'b1;
			return r;
		end else begin
			num = (sa < 0) ? -sa : sa;
			num = num << FRAC_BITS;
			den = (sb < 0) ? -sb : sb;
			mq = num / den;
			q = (a[DATA_W-1] ^ b[DATA_W-1]) ? -$signed(mq) : $signed(mq);
		end
		r.result = q[DATA_W-1:0];
		r.overflow = (q > Q_MAX) || (q < Q_MIN);
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_operand();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return r;
			4, 5, 6: return {{12{r[19]}}, r[19:0]};
			7: begin
				case (r[2:0])
					3'd0: return 32'h0000_0000;
					3'd1: return 32'h0000_0001;
					3'd2: return 32'hffff_ffff;
					3'd3: return 32'h0001_0000;
					3'd4: return 32'hffff_0000;
					3'd5: return 32'h7fff_ffff;
					3'd6: return 32'h8000_0000;
					default: return 32'h0000_8000;
				endcase
			end
			8: return {{8{r[7]}}, r[7:0], 16'h0000};
			default: return '0;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	task automatic send_item(op_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		q16_results_due.push_back(q16_compute(op, a, b));
	endtask

	task automatic drain_results();
		@(negedge clk) s_tvalid <= 1'b0;
		while (q16_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_multiply_corners();
		send_item(OP_MUL, 32'h0001_0000, 32'h0001_0000);
		send_item(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_MUL, 32'h8000_0000, 32'h7fff_ffff);
		send_item(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
		send_item(OP_MUL, 32'h0000_0001, 32'h0000_0001);
		send_item(OP_MUL, 32'hffff_8000, 32'h0001_0000);
		send_item(OP_MUL, 32'h7fff_ffff, 32'h0001_0000);
		send_item(OP_MUL, 32'h8000_0000, 32'hffff_0000);
		send_item(OP_MUL, 32'h0000_0000, 32'h8000_0000);
	endtask

	task automatic test_divide_corners();
		send_item(OP_DIV, 32'h0001_0000, 32'h0001_0000);
		send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_item(OP_DIV, 32'h8000_0000, 32'hffff_0000);
		send_item(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
		send_item(OP_DIV, 32'hffff_ffff, 32'h0000_0003);
		send_item(OP_DIV, 32'h0000_0007, 32'hffff_fffe);
		send_item(OP_DIV, 32'h0000_0000, 32'h0000_0005);
		send_item(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(OP_DIV, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_DIV, 32'h8000_0000, 32'h7fff_ffff);
	endtask

	task automatic test_zero_divisor();
		send_item(OP_DIV, 32'h0001_0000, 32'h0000_0000);
		send_item(OP_DIV, 32'h8000_0000, 32'h0000_0000);
		send_item(OP_DIV, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_DIV, 32'hffff_ffff, 32'h0000_0000);
	endtask

	task automatic test_random_mix(int count);
		op_t op;
		for (int i = 0; i < count; i++) begin
			op = op_t'($urandom_range(0, 1));
			send_item(op, pick_operand(), pick_operand());
			if (i == count / 2)
				drain_results();
		end
		drain_results();
	endtask

	always @(negedge clk)
		m_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (q16_results_due.size() == 0) begin
				report_mismatch("result with none due", m_tdata, '0);
			end else begin
				due_item = q16_results_due.pop_front();
				if (m_tdata !== due_item.result)
					report_mismatch("result", m_tdata, due_item.result);
				if (m_tuser[0] !== due_item.overflow)
					report_mismatch("overflow", DATA_W'(m_tuser[0]),
						DATA_W'(due_item.overflow));
				if (m_tuser[1] !== due_item.divide_by_zero)
					report_mismatch("divide_by_zero", DATA_W'(m_tuser[1]),
						DATA_W'(due_item.divide_by_zero));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 47;
		test_multiply_corners();
		test_divide_corners();
		test_zero_divisor();
		drain_results();
		test_random_mix(383);

		send_idle_pct = 47;
		recv_idle_pct = 12;
		test_random_mix(383);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(384);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
